/* sv/sync_length_frame_receiver_top_macros.svh */
// Assertion macros shared by the frame receiver RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SLFR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slfr assertion failed");
`define SLFR_ASSERT_NEVER(name, cond) `SLFR_ASSERT(name, !(cond))
`else
`define SLFR_ASSERT(name, prop)
`define SLFR_ASSERT_NEVER(name, cond)
`endif
`endif

/* sv/slfr_pkg.sv */
// Types and constants of the sync/length frame receiver.
// No dependencies; used by every module of the block except slfr_fifo.
package slfr_pkg;

  localparam int RecBytes = 24;
  localparam int IdxW = $clog2(RecBytes);
  localparam int TotalOutWidth = 48;
  localparam int LimitWidth = 31;

  localparam logic [7:0] HdrFirst = 8'hA5;
  localparam logic [7:0] HdrSecond = 8'h5A;
  localparam logic [LimitWidth-1:0] LimitReset = 31'd220;

  // Payload bytes of one completed frame; bytes past the frame length are zero.
  typedef logic [RecBytes-1:0][7:0] payload_t;

  typedef struct packed {
    logic signed [31:0] left_delta;
    logic signed [31:0] right_delta;
    logic [31:0] battery_bits;
    logic signed [TotalOutWidth-1:0] left_total;
    logic signed [TotalOutWidth-1:0] right_total;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } result_t;

endpackage

/* sv/sync_length_frame_receiver_top.sv */
// Usage
// Input: one received serial byte per beat on rx_byte_i, taken when push_i
// is high and full_o is low. Bytes are searched for the 0xA5 0x5A header;
// the byte after it is the payload length, and the next byte starts the
// payload. A new header restarts a frame already under way.
// Output: one result per completed frame, shown while empty_o is low and
// taken with pop_i. Results leave in frame order.
// Config: cfg_we_i writes cfg_wdata_i into the encoder limit; write it only
// while no frame is in flight.
// Throughput: one byte per cycle. full_o rises only when the byte at hand
// would complete a frame and the two-entry frame queue is full.
// Path: the edge that takes the byte completing a frame writes its record
// into the frame queue; the limit and total stage fills the result queue
// combinationally from there when it has room; that queue drives the ports.
// Stall: a held-off reader fills the result queue, then the frame queue;
// bytes that complete no frame are still taken meanwhile.
// Reset: history, frame state and wheel totals clear; limit becomes 220.
`include "sync_length_frame_receiver_top_macros.svh"
module sync_length_frame_receiver_top
  import slfr_pkg::*;
#(
  parameter int TOTAL_WIDTH = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            cfg_we_i,
  input  logic [LimitWidth-1:0]           cfg_wdata_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic signed [31:0]              left_delta_o,
  output logic signed [31:0]              right_delta_o,
  output logic [31:0]                     battery_bits_o,
  output logic signed [TotalOutWidth-1:0] left_total_o,
  output logic signed [TotalOutWidth-1:0] right_total_o,
  output logic signed [15:0]              accel_x_o,
  output logic signed [15:0]              accel_y_o,
  output logic signed [15:0]              accel_z_o,
  output logic signed [15:0]              gyro_x_o,
  output logic signed [15:0]              gyro_y_o,
  output logic signed [15:0]              gyro_z_o
);

  logic     will_complete, accept, rec_push;
  payload_t rec_in, rec_out;
  logic     mid_full, mid_empty, mid_pop;
  logic     res_push, out_full;
  result_t  res_in, res_out;

  assign full_o = mid_full && will_complete;
  assign accept = push_i && !full_o;

  slfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .will_complete_o (will_complete),
    .rec_push_o      (rec_push),
    .rec_o           (rec_in)
  );

  slfr_fifo #(
    .WIDTH ($bits(payload_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .pop_i   (mid_pop),
    .rdata_o (rec_out),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  slfr_back #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_valid_i (!mid_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (mid_pop),
    .res_ready_i (!out_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  slfr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop_i),
    .rdata_o (res_out),
    .full_o  (out_full),
    .empty_o (empty_o)
  );

  assign left_delta_o   = res_out.left_delta;
  assign right_delta_o  = res_out.right_delta;
  assign battery_bits_o = res_out.battery_bits;
  assign left_total_o   = res_out.left_total;
  assign right_total_o  = res_out.right_total;
  assign accel_x_o      = res_out.accel_x;
  assign accel_y_o      = res_out.accel_y;
  assign accel_z_o      = res_out.accel_z;
  assign gyro_x_o       = res_out.gyro_x;
  assign gyro_y_o       = res_out.gyro_y;
  assign gyro_z_o       = res_out.gyro_z;

  // A completed frame is never dropped at the frame queue.
  `SLFR_ASSERT_NEVER(a_rec_overflow, rec_push && mid_full)
  // A completed frame is waiting in the frame queue on the next cycle.
  `SLFR_ASSERT(a_rec_lands, rec_push |=> !mid_empty)
  // A result only appears after a frame record was waiting.
  `SLFR_ASSERT(a_res_from_rec, $fell(empty_o) |-> $past(!mid_empty))

endmodule

/* sv/slfr_fifo.sv */
// Small register-based queue used between and after the receiver stages.
// Depends on nothing; DEPTH must be a power of two of at least two.
module slfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0] wr_ptr_q, wr_ptr_d;
  logic [AW:0] rd_ptr_q, rd_ptr_d;
  logic do_push, do_pop;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
                   (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q[AW-1:0]];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

/* sv/slfr_front.sv */
// Front stage: header search, length tracking and payload capture per byte.
// Depends on slfr_pkg; hands a payload record out when a frame completes.
module slfr_front
  import slfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] rx_byte_i,
  output logic     will_complete_o,
  output logic     rec_push_o,
  output payload_t rec_o
);

  logic [7:0] newest_q, middle_q, oldest_q;
  logic       in_frame_q;
  logic [7:0] len_q, cnt_q;
  logic [7:0] pay_q [RecBytes];

  logic       hdr;
  logic       eff_in;
  logic [7:0] eff_len, eff_cnt, cnt_inc;

  // A header seen in the history restarts the frame at the incoming byte.
  assign hdr     = (oldest_q == HdrFirst) && (middle_q == HdrSecond) && (newest_q != 8'd0);
  assign eff_in  = hdr || in_frame_q;
  assign eff_len = hdr ? newest_q : len_q;
  assign eff_cnt = hdr ? 8'd0 : cnt_q;
  assign cnt_inc = eff_cnt + 8'd1;

  // Completion depends only on stored state, so it is known before the beat.
  assign will_complete_o = eff_in && (cnt_inc == eff_len);
  assign rec_push_o      = accept_i && will_complete_o;

  // Bytes at or past the frame length read as zero; every lower index was
  // written during the current frame, so stale bytes never leak out.
  always_comb begin
    for (int i = 0; i < RecBytes; i++) begin
      if (8'(i) < eff_len) begin
        rec_o[i] = (8'(i) == eff_cnt) ? rx_byte_i : pay_q[i];
      end else begin
        rec_o[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q   <= 8'd0;
      middle_q   <= 8'd0;
      oldest_q   <= 8'd0;
      in_frame_q <= 1'b0;
      len_q      <= 8'd0;
      cnt_q      <= 8'd0;
    end else if (accept_i) begin
      if (will_complete_o) begin
        newest_q   <= 8'd0;
        middle_q   <= 8'd0;
        oldest_q   <= 8'd0;
        in_frame_q <= 1'b0;
        len_q      <= 8'd0;
        cnt_q      <= 8'd0;
      end else begin
        oldest_q <= middle_q;
        middle_q <= newest_q;
        newest_q <= rx_byte_i;
        if (eff_in) begin
          in_frame_q <= 1'b1;
          len_q      <= eff_len;
          cnt_q      <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && eff_in && (eff_cnt < 8'(RecBytes))) begin
      pay_q[eff_cnt[IdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

/* sv/slfr_back.sv */
// Back stage: encoder limit check, wheel totals and result assembly.
// Depends on slfr_pkg; owns the encoder limit register.
module slfr_back
  import slfr_pkg::*;
#(
  parameter int TOTAL_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LimitWidth-1:0] cfg_wdata_i,
  input  logic                  rec_valid_i,
  input  payload_t              rec_i,
  output logic                  rec_pop_o,
  input  logic                  res_ready_i,
  output logic                  res_push_o,
  output result_t               res_o
);

  logic [LimitWidth-1:0] limit_q;
  logic [TOTAL_WIDTH-1:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic signed [31:0] lraw, rraw, ld, rd;
  logic signed [32:0] lim_pos, lim_neg;
  logic fire;

  assign fire       = rec_valid_i && res_ready_i;
  assign rec_pop_o  = fire;
  assign res_push_o = fire;

  assign lraw    = {rec_i[3], rec_i[2], rec_i[1], rec_i[0]};
  assign rraw    = {rec_i[7], rec_i[6], rec_i[5], rec_i[4]};
  assign lim_pos = {2'b00, limit_q};
  assign lim_neg = -lim_pos;

  assign ld = ((33'(lraw) > lim_pos) || (33'(lraw) < lim_neg)) ? 32'sd0 : lraw;
  assign rd = ((33'(rraw) > lim_pos) || (33'(rraw) < lim_neg)) ? 32'sd0 : rraw;

  assign lsum_d = lsum_q + TOTAL_WIDTH'(ld);
  assign rsum_d = rsum_q + TOTAL_WIDTH'(rd);

  always_comb begin
    res_o.left_delta   = ld;
    res_o.right_delta  = rd;
    res_o.battery_bits = {rec_i[11], rec_i[10], rec_i[9], rec_i[8]};
    res_o.left_total   = TotalOutWidth'(lsum_d);
    res_o.right_total  = TotalOutWidth'(rsum_d);
    res_o.accel_x      = {rec_i[13], rec_i[12]};
    res_o.accel_y      = {rec_i[15], rec_i[14]};
    res_o.accel_z      = {rec_i[17], rec_i[16]};
    res_o.gyro_x       = {rec_i[19], rec_i[18]};
    res_o.gyro_y       = {rec_i[21], rec_i[20]};
    res_o.gyro_z       = {rec_i[23], rec_i[22]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      lsum_q  <= '0;
      rsum_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (fire) begin
        lsum_q <= lsum_d;
        rsum_q <= rsum_d;
      end
    end
  end

endmodule

/* sim/sync_length_frame_receiver_top_tb.sv */
// Testbench for the sync/length frame receiver: header search, restarts, short and long
// frames, encoder limits and wheel totals, all checked against a local frame predictor.
// Depends on slfr_pkg and sync_length_frame_receiver_top.
`timescale 1ns / 1ps
module sync_length_frame_receiver_top_tb;
  import slfr_pkg::*;

  localparam int Settle = 8;
  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 30;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push_i;
  logic full_o;
  logic [7:0] rx_byte_i;
  logic cfg_we_i;
  logic [LimitWidth-1:0] cfg_wdata_i;
  logic empty_o;
  logic pop_i;
  logic signed [31:0] left_delta_o;
  logic signed [31:0] right_delta_o;
  logic [31:0] battery_bits_o;
  logic signed [TotalOutWidth-1:0] left_total_o;
  logic signed [TotalOutWidth-1:0] right_total_o;
  logic signed [15:0] accel_x_o;
  logic signed [15:0] accel_y_o;
  logic signed [15:0] accel_z_o;
  logic signed [15:0] gyro_x_o;
  logic signed [15:0] gyro_y_o;
  logic signed [15:0] gyro_z_o;

  sync_length_frame_receiver_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push_i),
    .full_o(full_o),
    .rx_byte_i(rx_byte_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .empty_o(empty_o),
    .pop_i(pop_i),
    .left_delta_o(left_delta_o),
    .right_delta_o(right_delta_o),
    .battery_bits_o(battery_bits_o),
    .left_total_o(left_total_o),
    .right_total_o(right_total_o),
    .accel_x_o(accel_x_o),
    .accel_y_o(accel_y_o),
    .accel_z_o(accel_z_o),
    .gyro_x_o(gyro_x_o),
    .gyro_y_o(gyro_y_o),
    .gyro_z_o(gyro_z_o)
  );

  always #2 clk_i = ~clk_i;

  // Frame predictor state.
  logic [7:0] hist_new, hist_mid, hist_old;
  logic framing;
  logic [7:0] flen, fcount;
  logic [7:0] store [RecBytes];
  logic [TotalOutWidth-1:0] left_acc, right_acc;
  logic [LimitWidth-1:0] enc_limit;
  result_t expected_frames [$];

  int frames_predicted = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int reader_hold = 0;
  bit allow_idle = 1'b1;

  task automatic clear_frame();
    hist_new = 8'h00;
    hist_mid = 8'h00;
    hist_old = 8'h00;
    framing = 1'b0;
    flen = 8'h00;
    fcount = 8'h00;
    foreach (store[i]) store[i] = 8'h00;
  endtask

  function automatic logic [7:0] payload_byte(int i);
    if (i < int'(flen) && i < RecBytes) return store[i[IdxW-1:0]];
    return 8'h00;
  endfunction

  function automatic logic [31:0] payload_word(int i);
    return {payload_byte(i + 3), payload_byte(i + 2), payload_byte(i + 1), payload_byte(i)};
  endfunction

  function automatic logic [15:0] payload_half(int i);
    return {payload_byte(i + 1), payload_byte(i)};
  endfunction

  function automatic logic [31:0] bounded_delta(logic [31:0] raw);
    longint v, lim;
    v = longint'(signed'(raw));
    lim = longint'(enc_limit);
    if (v > lim || v < -lim) return 32'h0;
    return raw;
  endfunction

  // Advances the predictor by one accepted byte and queues a result on frame completion.
  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    logic [31:0] ld, rd;
    if (hist_old == HdrFirst && hist_mid == HdrSecond && hist_new != 8'h00) begin
      flen = hist_new;
      framing = 1'b1;
      fcount = 8'h00;
    end
    if (framing) begin
      if (fcount < RecBytes) store[fcount[IdxW-1:0]] = b;
      fcount = fcount + 8'd1;
      if (fcount == flen) begin
        ld = bounded_delta(payload_word(0));
        rd = bounded_delta(payload_word(4));
        left_acc = left_acc + {{(TotalOutWidth - 32){ld[31]}}, ld};
        right_acc = right_acc + {{(TotalOutWidth - 32){rd[31]}}, rd};
        r.left_delta = ld;
        r.right_delta = rd;
        r.battery_bits = payload_word(8);
        r.left_total = left_acc;
        r.right_total = right_acc;
        r.accel_x = payload_half(12);
        r.accel_y = payload_half(14);
        r.accel_z = payload_half(16);
        r.gyro_x = payload_half(18);
        r.gyro_y = payload_half(20);
        r.gyro_z = payload_half(22);
        expected_frames = {expected_frames, r};
        frames_predicted++;
        // A completed frame wipes the history, so the byte is not shifted in.
        clear_frame();
        return;
      end
    end
    hist_old = hist_mid;
    hist_mid = hist_new;
    hist_new = b;
  endtask

  // Sends one beat; returns at the falling edge after acceptance with push still high.
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = allow_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      push_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push_i = 1'b1;
    rx_byte_i = value;
    do @(posedge clk_i); while (full_o);
    parse_byte(value);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    push_i = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [LimitWidth-1:0] value);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    enc_limit = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Deltas cluster around the limit edges so both sides of the test are hit.
  function automatic logic [31:0] pick_delta();
    longint lim, v;
    lim = longint'(enc_limit);
    case ($urandom_range(0, 6))
      0: v = lim;
      1: v = -lim;
      2: v = lim + 1;
      3: v = -lim - 1;
      4, 5: v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
      default: v = longint'($urandom());
    endcase
    return v[31:0];
  endfunction

  task automatic send_random_frame();
    int len, sent, kind;
    logic [31:0] ld, rd;
    logic [7:0] b;
    kind = $urandom_range(0, 19);
    if (kind < 12) len = $urandom_range(1, 12);
    else if (kind < 17) len = $urandom_range(13, 26);
    else if (kind == 17) len = RecBytes;
    else if (kind == 18) len = $urandom_range(27, 60);
    else len = $urandom_range(61, 255);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 5)) send_byte(8'($urandom()));
    if ($urandom_range(0, 11) == 0) begin
      send_byte(HdrFirst);
      send_byte(HdrSecond);
      send_byte(8'h00);
    end
    ld = pick_delta();
    rd = pick_delta();
    // Now and then the frame is cut short, so the next header restarts it.
    sent = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_byte(8'(len));
    for (int i = 0; i < sent; i++) begin
      if (i < 4) b = ld[8 * i +: 8];
      else if (i < 8) b = rd[8 * (i - 4) +: 8];
      else b = 8'($urandom());
      send_byte(b);
    end
  endtask

  task automatic test_header_cases();
    logic [7:0] seq [0:29];
    // Zero-length header, a frame restarted from inside its own payload (short frame
    // reading zeros), then deltas on both sides of the reset limit.
    seq = '{8'hA5, 8'h5A, 8'h00, 8'hA5, 8'h5A, 8'h0A, 8'h11, 8'hA5, 8'h5A, 8'h02,
            8'hDC, 8'hFF,
            8'hA5, 8'h5A, 8'h08, 8'hDC, 8'h00, 8'h00, 8'h00, 8'h24, 8'hFF, 8'hFF, 8'hFF,
            8'hA5, 8'h5A, 8'h04, 8'h23, 8'hFF, 8'hFF, 8'hFF};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_frames(input logic [LimitWidth-1:0] limit, input bit idle,
                                    input int byte_budget);
    int start_bytes, start_frames;
    wait_idle();
    set_limit(limit);
    allow_idle = idle;
    start_bytes = bytes_sent;
    start_frames = frames_predicted;
    while (bytes_sent - start_bytes < byte_budget || frames_predicted - start_frames < 2)
      send_random_frame();
  endtask

  task automatic test_backpressure();
    wait_idle();
    allow_idle = 1'b0;
    reader_hold = 300;
    // One-byte frames back to back fill both queues while the reader holds off.
    repeat (15) begin
      send_byte(HdrFirst);
      send_byte(HdrSecond);
      send_byte(8'h01);
      send_byte(8'($urandom()));
    end
    wait_idle();
    allow_idle = 1'b1;
    repeat (5) send_random_frame();
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MaxPrinted)
      $display("mismatch in result %0d, %s: got %0h, expected %0h",
               results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result with none expected", 64'(left_delta_o), 64'h0);
      end else begin
        want = expected_frames.pop_front();
        if (left_delta_o !== want.left_delta)
          report_mismatch("left_delta", 64'(left_delta_o), 64'(want.left_delta));
        if (right_delta_o !== want.right_delta)
          report_mismatch("right_delta", 64'(right_delta_o), 64'(want.right_delta));
        if (battery_bits_o !== want.battery_bits)
          report_mismatch("battery_bits", 64'(battery_bits_o), 64'(want.battery_bits));
        if (left_total_o !== want.left_total)
          report_mismatch("left_total", 64'(left_total_o), 64'(want.left_total));
        if (right_total_o !== want.right_total)
          report_mismatch("right_total", 64'(right_total_o), 64'(want.right_total));
        if (accel_x_o !== want.accel_x)
          report_mismatch("accel_x", 64'(accel_x_o), 64'(want.accel_x));
        if (accel_y_o !== want.accel_y)
          report_mismatch("accel_y", 64'(accel_y_o), 64'(want.accel_y));
        if (accel_z_o !== want.accel_z)
          report_mismatch("accel_z", 64'(accel_z_o), 64'(want.accel_z));
        if (gyro_x_o !== want.gyro_x)
          report_mismatch("gyro_x", 64'(gyro_x_o), 64'(want.gyro_x));
        if (gyro_y_o !== want.gyro_y)
          report_mismatch("gyro_y", 64'(gyro_y_o), 64'(want.gyro_y));
        if (gyro_z_o !== want.gyro_z)
          report_mismatch("gyro_z", 64'(gyro_z_o), 64'(want.gyro_z));
      end
      results_seen++;
    end
  end

  // The reader drains results with random stalls, and holds off entirely when asked.
  initial begin : result_reader
    int stall;
    pop_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (reader_hold > 0) begin
        pop_i = 1'b0;
        repeat (reader_hold) @(negedge clk_i);
        reader_hold = 0;
      end
      stall = allow_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        pop_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop_i = 1'b1;
      do @(posedge clk_i); while (empty_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sync_length_frame_receiver_top_tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    push_i = 1'b0;
    rx_byte_i = 8'h00;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    clear_frame();
    left_acc = '0;
    right_acc = '0;
    enc_limit = LimitReset;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_header_cases();
    test_random_frames('0, 1'b0, 20);
    test_random_frames('1, 1'b1, 20);
    test_random_frames(LimitWidth'($urandom_range(1, 2000)), 1'b1, 20);
    test_random_frames(LimitWidth'($urandom()), 1'b1, 20);
    test_random_frames(LimitReset, 1'b1, 20);
    test_backpressure();
    wait_idle();

    if (mismatches == 0) begin
      $display("sync_length_frame_receiver_top_tb OK");
    end else begin
      $display("sync_length_frame_receiver_top_tb NOT OK");
    end
    $finish;
  end

endmodule
